// ===== src/adc_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, density table, beat structs and table lookup for the airspeed converter
package adc_pkg;

	// field widths
	localparam int SPEED_W = 16;
	localparam int ALT_W   = 16;
	localparam int OUT_W   = 18;
	localparam int DENS_W  = 16;
	localparam int FEET_W  = 17;

	// conversion direction codes
	localparam logic MODE_TAS_TO_IAS = 1'b0;
	localparam logic MODE_IAS_TO_TAS = 1'b1;

	// altitude binning
	localparam int TABLE_ENTRIES  = 71;
	localparam int BIN_FEET       = 1000;
	localparam int FEET_PER_M_Q14 = 53753;
	localparam int MAX_FEET       = 69999;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	// density table, q1.15, one entry per bin boundary
	localparam int ROM_SIZE = 71;
	localparam int ROM_AW   = $clog2(ROM_SIZE);

	localparam logic [DENS_W-1:0] DENSITY_ROM [ROM_SIZE] = '{
		16'd32768, 16'd32276, 16'd31818, 16'd31359, 16'd30867, 16'd30409, 16'd29950,
		16'd29491, 16'd29065, 16'd28606, 16'd28148, 16'd27722, 16'd27296, 16'd26837,
		16'd26411, 16'd25985, 16'd25559, 16'd25166, 16'd24740, 16'd24314, 16'd23921,
		16'd23527, 16'd23101, 16'd22708, 16'd22315, 16'd21922, 16'd21398, 16'd21168,
		16'd20808, 16'd20414, 16'd20054, 16'd19694, 16'd19300, 16'd18940, 16'd18612,
		16'd18252, 16'd17891, 16'd17465, 16'd17072, 16'd16646, 16'd16253, 16'd15892,
		16'd15499, 16'd15139, 16'd14778, 16'd14418, 16'd14090, 16'd13730, 16'd13402,
		16'd13107, 16'd12780, 16'd12485, 16'd12190, 16'd11895, 16'd11600, 16'd11338,
		16'd11043, 16'd10781, 16'd10551, 16'd10289, 16'd10060, 16'd9798,  16'd9568,
		16'd9339,  16'd9110,  16'd8913,  16'd8684,  16'd8487,  16'd8258,  16'd8061,
		16'd7897
	};

	// item data carried beside the density pipeline
	typedef struct packed {
		logic               func;
		logic [SPEED_W-1:0] speed;
	} adc_side_t;

	// front pipeline result handed to the conversion stage
	typedef struct packed {
		logic               func;
		logic [SPEED_W-1:0] speed;
		logic [DENS_W-1:0]  density;
	} adc_dens_t;

	// one beat moving along the divider cell row
	typedef struct packed {
		logic              func;
		logic              sat;
		logic [DENS_W-1:0] rem;
		logic [DENS_W-1:0] dvsr;
		logic [OUT_W-1:0]  acc;
	} adc_lane_t;

	// reads past the stored entries give the last entry
	function automatic logic [DENS_W-1:0] rom_read(input logic [ROM_AW-1:0] idx);
		logic [DENS_W-1:0] val;
		if (idx >= ROM_AW'(ROM_SIZE - 1)) begin
			val = DENSITY_ROM[ROM_SIZE-1];
		end else begin
			val = DENSITY_ROM[idx];
		end
		return val;
	endfunction

endpackage

// ===== src/adc_front.sv =====
`timescale 1ns / 1ps
// altitude to density factor pipeline: feet conversion, binning and table interpolation
module adc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          item_valid,
	input  logic                          func,
	input  logic [adc_pkg::SPEED_W-1:0]   speed_in,
	input  logic signed [adc_pkg::ALT_W-1:0] altitude_m,
	output logic                          dens_vld,
	output adc_pkg::adc_dens_t            dens
);
	import adc_pkg::*;

	localparam int STAGES  = 10;
	localparam int NUM_MAX = 32768 * BIN_FEET + BIN_FEET / 2;
	localparam int NUM_W   = $clog2(NUM_MAX + 1);
	localparam int DIV_W   = (NUM_W > FEET_W) ? NUM_W : FEET_W;
	localparam longint RECIP_L = (longint'(1) << DIV_W) / BIN_FEET;
	localparam int RECIP_W = $clog2(RECIP_L + 1);
	localparam int REM_W   = $clog2(2 * BIN_FEET);
	localparam int FRAC_W  = (BIN_FEET > 1) ? $clog2(BIN_FEET) : 1;
	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int DIFF_W  = DENS_W + 1;
	localparam int SUM_W   = DIV_W + 4;
	localparam int PROD_W  = ALT_W - 1 + 16;

	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
	localparam logic [DIV_W-1:0]   BIN_D     = DIV_W'(BIN_FEET);
	localparam logic [REM_W-1:0]   BIN_R     = REM_W'(BIN_FEET);
	localparam logic [SUM_W-1:0]   BIN_S     = SUM_W'(BIN_FEET);
	localparam logic [DIV_W-1:0]   LAST_BIN  = DIV_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [FEET_W-1:0]  MAX_FT    = FEET_W'(MAX_FEET);
	localparam logic [15:0]        FT_PER_M  = 16'(FEET_PER_M_Q14);

	// floor(x / BIN_FEET) or one less
	function automatic logic [DIV_W-1:0] cdiv_est(input logic [DIV_W-1:0] x);
		logic [DIV_W+RECIP_W-1:0] p;
		p = (DIV_W+RECIP_W)'(x) * (DIV_W+RECIP_W)'(RECIP);
		return DIV_W'(p >> DIV_W);
	endfunction

	logic            vld_s  [1:STAGES];
	adc_side_t       side_s [1:STAGES];

	logic [PROD_W-1:0] prod_s1;
	logic [FEET_W-1:0] feet_s2;
	logic [DIV_W-1:0]  feet_s3, est_s3;
	logic [DIV_W-1:0]  est_s4;
	logic [REM_W-1:0]  rem_s4;
	logic [DIV_W-1:0]  bin_s5;
	logic [FRAC_W-1:0] frac_s5;
	logic [DENS_W-1:0] lo_s6;
	logic signed [DIFF_W-1:0] diff_s6;
	logic [FRAC_W-1:0] frac_s6;
	logic [DIV_W-1:0]  num_s7;
	logic [DIV_W-1:0]  num_s8, est_s8;
	logic [DIV_W-1:0]  est_s9;
	logic [REM_W-1:0]  rem_s9;
	logic [DENS_W-1:0] dens_s10;

	logic [FEET_W-1:0] feet_raw;
	logic              use_last;
	logic [IDX_W-1:0]  lo_idx, hi_idx;
	logic [DENS_W-1:0] lo_val, hi_val;
	logic signed [DIFF_W+FRAC_W:0] dprod;
	logic [SUM_W-1:0]  num_sum;
	logic [DIV_W-1:0]  dens_q;

	always_comb begin
		feet_raw = prod_s1[PROD_W-1:14];
		use_last = bin_s5 >= LAST_BIN;
		lo_idx   = use_last ? LAST_IDX : bin_s5[IDX_W-1:0];
		hi_idx   = use_last ? LAST_IDX : lo_idx + IDX_W'(1);
		lo_val   = rom_read(ROM_AW'(lo_idx));
		hi_val   = rom_read(ROM_AW'(hi_idx));
		dprod    = diff_s6 * $signed({1'b0, frac_s6});
		num_sum  = SUM_W'(lo_s6) * BIN_S + SUM_W'(dprod) + SUM_W'(BIN_FEET / 2);
		dens_q   = (rem_s9 >= BIN_R) ? est_s9 + DIV_W'(1) : est_s9;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= STAGES; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= item_valid;
			for (int k = 2; k <= STAGES; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= '{func: func, speed: speed_in};
			for (int k = 2; k <= STAGES; k++) side_s[k] <= side_s[k-1];

			// metres to feet, negatives give zero
			prod_s1 <= altitude_m[ALT_W-1] ? '0 : PROD_W'(altitude_m[ALT_W-2:0]) * PROD_W'(FT_PER_M);
			feet_s2 <= (feet_raw > MAX_FT) ? MAX_FT : feet_raw;

			// bin and offset within the bin
			feet_s3 <= DIV_W'(feet_s2);
			est_s3  <= cdiv_est(DIV_W'(feet_s2));
			est_s4  <= est_s3;
			rem_s4  <= REM_W'(feet_s3 - est_s3 * BIN_D);
			if (rem_s4 >= BIN_R) begin
				bin_s5  <= est_s4 + DIV_W'(1);
				frac_s5 <= FRAC_W'(rem_s4 - BIN_R);
			end else begin
				bin_s5  <= est_s4;
				frac_s5 <= FRAC_W'(rem_s4);
			end

			// table lookup, beyond the last bin the last entry stands alone
			lo_s6   <= lo_val;
			diff_s6 <= use_last ? '0 : $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});
			frac_s6 <= use_last ? '0 : frac_s5;

			// rounded interpolation
			num_s7 <= num_sum[DIV_W-1:0];
			num_s8 <= num_s7;
			est_s8 <= cdiv_est(num_s7);
			est_s9 <= est_s8;
			rem_s9 <= REM_W'(num_s8 - est_s8 * BIN_D);
			dens_s10 <= (dens_q == '0) ? DENS_W'(1) : DENS_W'(dens_q);
		end
	end

	assign dens_vld = vld_s[STAGES];
	assign dens     = '{func: side_s[STAGES].func, speed: side_s[STAGES].speed,
		density: dens_s10};

endmodule

// ===== src/adc_div_cell.sv =====
`timescale 1ns / 1ps
// one restoring divider cell: resolves one quotient bit and hands the beat on
module adc_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               feed_vld,
	input  adc_pkg::adc_lane_t feed,
	output logic               vld,
	output adc_pkg::adc_lane_t lane
);
	import adc_pkg::*;

	logic              vld_q;
	adc_lane_t         lane_q;
	adc_lane_t         nxt;
	logic [DENS_W:0]   trial;
	logic              fits;

	always_comb begin
		nxt   = feed;
		trial = {feed.rem, feed.acc[OUT_W-1]};
		fits  = trial >= {1'b0, feed.dvsr};
		// only unsaturated divides iterate, other beats pass untouched
		if (feed.func == MODE_IAS_TO_TAS && !feed.sat) begin
			nxt.rem = fits ? DENS_W'(trial - {1'b0, feed.dvsr}) : DENS_W'(trial);
			nxt.acc = {feed.acc[OUT_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= feed_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt;
		end
	end

	assign vld  = vld_q;
	assign lane = lane_q;

endmodule

// ===== src/airspeed_density_conversion_top.sv =====
`timescale 1ns / 1ps
// airspeed converter top: density pipeline, conversion stage and divider cell row
// a result passes through 10 density stages, 1 conversion stage and 18 divider cells
// throughput: one item per cycle; the whole pipeline holds only while a result is stalled
// reset: arst_n clears every valid bit at once, payload registers are not reset
// no start-up sweep, items are taken in the first cycle after reset
module airspeed_density_conversion_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           func,
	input  logic [adc_pkg::SPEED_W-1:0]    speed_in,
	input  logic signed [adc_pkg::ALT_W-1:0] altitude_m,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [adc_pkg::OUT_W-1:0]      speed_out,
	output logic                           saturated
);
	import adc_pkg::*;

	localparam int NUM_W = SPEED_W + 16;
	localparam int HI_W  = NUM_W - OUT_W;
	localparam logic [NUM_W-1:0] HALF_Q15 = NUM_W'(16384);

	// every stage moves together unless the output beat is held
	logic en;
	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	// density factor for each item
	logic      dens_vld;
	adc_dens_t dens;

	adc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.item_valid (item_valid),
		.func       (func),
		.speed_in   (speed_in),
		.altitude_m (altitude_m),
		.dens_vld   (dens_vld),
		.dens       (dens)
	);

	// conversion stage: the multiply finishes here, a divide is checked for overflow
	// and loaded into the cell row as remainder plus dividend bits
	logic [NUM_W-1:0] mprod;
	logic [NUM_W-1:0] mrnd;
	logic [NUM_W-1:0] numer;
	logic [HI_W-1:0]  nhi;
	logic             ovf;
	adc_lane_t        prep_nxt;
	logic             prep_vld_s11;
	adc_lane_t        prep_s11;

	always_comb begin
		mprod = NUM_W'(dens.speed) * NUM_W'(dens.density);
		mrnd  = mprod + HALF_Q15;
		numer = {1'b0, dens.speed, 15'b0} + NUM_W'(dens.density >> 1);
		nhi   = numer[NUM_W-1:OUT_W];
		// quotient fits the output only if the upper dividend part is below the divisor
		ovf   = {{(DENS_W-HI_W){1'b0}}, nhi} >= dens.density;

		prep_nxt.func = dens.func;
		prep_nxt.dvsr = dens.density;
		if (dens.func == MODE_TAS_TO_IAS) begin
			prep_nxt.sat = 1'b0;
			prep_nxt.rem = '0;
			prep_nxt.acc = OUT_W'(mrnd >> 15);
		end else if (ovf) begin
			prep_nxt.sat = 1'b1;
			prep_nxt.rem = '0;
			prep_nxt.acc = OUT_MAX;
		end else begin
			prep_nxt.sat = 1'b0;
			prep_nxt.rem = DENS_W'(nhi);
			prep_nxt.acc = numer[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_s11 <= 1'b0;
		end else if (en) begin
			prep_vld_s11 <= dens_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s11 <= prep_nxt;
		end
	end

	// divider cell row, one quotient bit per cell, msb first
	logic      chain_vld [OUT_W+1];
	adc_lane_t chain     [OUT_W+1];

	assign chain_vld[0] = prep_vld_s11;
	assign chain[0]     = prep_s11;

	for (genvar g = 0; g < OUT_W; g++) begin : g_cell
		adc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.feed_vld (chain_vld[g]),
			.feed     (chain[g]),
			.vld      (chain_vld[g+1]),
			.lane     (chain[g+1])
		);
	end

	// last cell doubles as the output register
	assign result_valid = chain_vld[OUT_W];
	assign speed_out    = chain[OUT_W].acc;
	assign saturated    = chain[OUT_W].sat;

`ifndef SYNTHESIS
	a_sat_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> speed_out == OUT_MAX)
		else $error("saturated result not at maximum");

	a_mul_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && chain[OUT_W].func == MODE_TAS_TO_IAS
		|-> !saturated && speed_out[OUT_W-1:OUT_W-2] == 2'b00)
		else $error("multiply result out of range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && chain[OUT_W].func == MODE_IAS_TO_TAS && !saturated
		|-> chain[OUT_W].rem < chain[OUT_W].dvsr)
		else $error("divider remainder not below divisor");

	a_dens_range: assert property (@(posedge clk) disable iff (!arst_n)
		dens_vld |-> dens.density != '0 && dens.density <= DENS_W'(32768))
		else $error("density factor out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the airspeed density converter top level
module testbench;
	import adc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;     // margin past the pipeline depth
	localparam int HOLD_CYCLES  = 400;    // long receiver hold to back the pipe up
	localparam int RANDOM_ITEMS = 1700;
	localparam int SEGMENT_LEN  = 100;

	// one input beat plus the idle cycles the sender waits before offering it
	typedef struct {
		logic               func;
		logic [SPEED_W-1:0] speed;
		logic [ALT_W-1:0]   alt;
		int unsigned        gap;
	} conv_item_t;

	// one predicted output beat
	typedef struct {
		logic [OUT_W-1:0] speed;
		logic             sat;
	} conv_result_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_stall;
	logic                      func = 1'b0;
	logic [SPEED_W-1:0]        speed_in = '0;
	logic signed [ALT_W-1:0]   altitude_m = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [OUT_W-1:0]          speed_out;
	logic                      saturated;

	conv_item_t   items_to_send[$];
	conv_result_t conversions_due[$];

	int          items_total;
	int          items_accepted;
	int          results_seen;
	int          error_count;
	int          cycle_count;
	int unsigned gap_left;
	bit          gap_armed;
	int unsigned stall_left;
	int unsigned hold_left;
	bit          rx_calm;

	airspeed_density_conversion_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.speed_in     (speed_in),
		.altitude_m   (altitude_m),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.speed_out    (speed_out),
		.saturated    (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// density table entry, reads past the end give the last stored value
	function automatic longint unsigned density_entry(input longint unsigned idx);
		if (idx >= ROM_SIZE) begin
			return longint'(DENSITY_ROM[ROM_SIZE-1]);
		end
		return longint'(DENSITY_ROM[idx[ROM_AW-1:0]]);
	endfunction

	// expected conversion of one beat
	function automatic conv_result_t predict_conversion(input logic mode,
			input logic [SPEED_W-1:0] spd, input logic [ALT_W-1:0] alt);
		longint unsigned feet, bin, frac, lo, hi, dens, quot, spd64;
		conv_result_t    res;
		spd64 = {48'd0, spd};
		feet = 0;
		// negative altitude stays at sea level, high altitude clamps to the ceiling
		if (!alt[ALT_W-1]) begin
			feet = ({48'd0, alt} * longint'(FEET_PER_M_Q14)) >> 14;
			if (feet > MAX_FEET) begin
				feet = MAX_FEET;
			end
		end
		bin  = feet / BIN_FEET;
		frac = feet % BIN_FEET;
		if (bin >= TABLE_ENTRIES - 1) begin
			// beyond the last bin: no interpolation
			dens = density_entry(TABLE_ENTRIES - 1);
		end else begin
			lo   = density_entry(bin);
			hi   = density_entry(bin + 1);
			dens = (lo * (BIN_FEET - frac) + hi * frac + BIN_FEET / 2) / BIN_FEET;
		end
		if (dens == 0) begin
			dens = 1;
		end
		if (mode == MODE_TAS_TO_IAS) begin
			quot = (spd64 * dens + 64'd16384) >> 15;
		end else begin
			quot = ((spd64 << 15) + (dens >> 1)) / dens;
		end
		res.sat = 1'b0;
		if (quot > OUT_MAX) begin
			quot    = OUT_MAX;
			res.sat = 1'b1;
		end
		res.speed = quot[OUT_W-1:0];
		return res;
	endfunction

	function automatic conv_item_t make_item(input logic mode, input int unsigned spd,
			input int alt, input int unsigned gap);
		conv_item_t it;
		it.func  = mode;
		it.speed = spd[SPEED_W-1:0];
		it.alt   = alt[ALT_W-1:0];
		it.gap   = gap;
		return it;
	endfunction

	// sender: offers queued beats, each after its own idle gap, holds while stalled
	always @(posedge clk) begin : drive_items
		conv_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			gap_armed = 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				// beat taken at this edge, its result is owed
				conversions_due.push_back(predict_conversion(func, speed_in, altitude_m));
				items_accepted++;
			end
			if (!item_valid || !item_stall) begin
				if (!gap_armed && items_to_send.size() > 0) begin
					gap_left  = items_to_send[0].gap;
					gap_armed = 1'b1;
				end
				if (gap_armed && gap_left == 0) begin
					nxt = items_to_send.pop_front();
					func       <= nxt.func;
					speed_in   <= nxt.speed;
					altitude_m <= nxt.alt;
					item_valid <= 1'b1;
					gap_armed = 1'b0;
				end else begin
					item_valid <= 1'b0;
					if (gap_armed) begin
						gap_left--;
					end
				end
			end
		end
	end

	// receiver: checks every accepted beat, stalls at random, holds off twice for a long stretch
	always @(posedge clk) begin : collect_results
		conv_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
			rx_calm    = 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (conversions_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, speed_out %0d saturated %0d",
						$time, speed_out, saturated);
					error_count++;
				end else begin
					want = conversions_due.pop_front();
					if (speed_out !== want.speed) begin
						$display("%0t: speed_out expected %0d got %0d", $time, want.speed, speed_out);
						error_count++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %0d got %0d", $time, want.sat, saturated);
						error_count++;
					end
				end
				results_seen++;
				// every hundred beats pick whether the receiver runs without stalls
				if (results_seen % SEGMENT_LEN == 0) begin
					rx_calm = ($urandom_range(0, 2) == 0);
				end
				stall_left = rx_calm ? 0 : $urandom_range(0, 11);
				// long hold: the sender keeps offering so the pipe fills and item_stall rises
				if (results_seen == 250 || results_seen == 1100) begin
					hold_left = HOLD_CYCLES;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats accepted, %0d results owed", $time,
				items_accepted, conversions_due.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		int          dir_alt[8];
		int          dir_spd[8];
		int          seg_kind;
		int          alt;
		int unsigned spd;
		int unsigned gap;
		logic        mode;

		// sea level, below zero, bin edge at 1000 ft, last bin, ceiling and past it
		dir_alt = '{-32768, -1, 0, 305, 21300, 21336, 21337, 32767};
		dir_spd = '{0, 65535, 1, 65535, 16, 65535, 40000, 65535};
		for (int m = 0; m < 2; m++) begin
			for (int i = 0; i < 8; i++) begin
				items_to_send.push_back(make_item(m[0], dir_spd[i], dir_alt[i], 0));
			end
		end
		// divide near the saturation threshold, at full speed
		for (int i = 0; i < 5; i++) begin
			items_to_send.push_back(make_item(MODE_IAS_TO_TAS, 65535, 20500 + 100 * i, i));
		end
		// multiply at the top of the speed range, top and bottom of the altitude range, then divide at zero and mid speed
		items_to_send.push_back(make_item(MODE_TAS_TO_IAS, 65535, 0, 1));
		items_to_send.push_back(make_item(MODE_TAS_TO_IAS, 65535, 32767, 0));
		items_to_send.push_back(make_item(MODE_IAS_TO_TAS, 0, 32767, 3));
		items_to_send.push_back(make_item(MODE_IAS_TO_TAS, 32768, 10000, 0));

		// random part, in segments with different sender pacing
		seg_kind = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % SEGMENT_LEN == 0) begin
				seg_kind = $urandom_range(0, 3);
			end
			case (seg_kind)
				0: begin
					gap = 0;
				end
				3: begin
					gap = ($urandom_range(0, 7) == 0) ? 11 : 0;
				end
				default: begin
					gap = $urandom_range(0, 11);
				end
			endcase
			mode = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: spd = $urandom;
				1: spd = 65535 - $urandom_range(0, 600);
				2: spd = $urandom_range(0, 255);
				default: spd = $urandom;
			endcase
			case ($urandom_range(0, 7))
				0, 1: begin
					alt = $urandom;
				end
				2, 3, 4: begin
					alt = $urandom_range(0, 21336);
				end
				5: begin
					// top bins, clamp edge and the divide saturation region
					alt = $urandom_range(20000, 21400);
				end
				6: begin
					// on or right next to a bin edge
					alt = ($urandom_range(0, 70) * BIN_FEET * 16384) / FEET_PER_M_Q14
						+ $urandom_range(0, 1);
				end
				default: begin
					alt = -int'($urandom_range(1, 32768));
				end
			endcase
			items_to_send.push_back(make_item(mode, spd, alt, gap));
		end
		items_total = items_to_send.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (items_accepted < items_total) @(posedge clk);
		while (conversions_due.size() > 0) @(posedge clk);
		// let any stray beat show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
